// ----- hw/rtl/fpr_pkg.sv -----
// Package for the focus priority request picker.
// Holds sizes, codes, sequencer states and the structs shared by the block's modules.
// No dependencies.
`default_nettype none

package fpr_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int PRI_W       = 2;
    localparam int ENTRY_W     = KEY_W + PRI_W;

    localparam int LIMIT_W = 7;
    localparam int SLACK_W = 6;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);
    localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(10);

    localparam logic [PRI_W-1:0] PRI_FOCUS = 2'd2;
    localparam logic [PRI_W-1:0] PRI_NEAR  = 2'd1;
    localparam logic [PRI_W-1:0] PRI_VIEW  = 2'd0;

    localparam logic OP_POST = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_TRIM_LIMIT = 1'b0;
    localparam logic CFG_TRIM_SLACK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POST_SWEEP,
        ST_TICK_SCAN,
        ST_TICK_PLAN,
        ST_TICK_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [SLACK_W-1:0] slack;
    } t_trim_cfg;

    typedef struct packed {
        logic             tick;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] e_key;
        logic [PRI_W-1:0] e_pri;
        logic [IDX_W-1:0] pos;
        logic             pick_vld;
        logic             pick_is2;
        logic [IDX_W-1:0] pick;
        logic [CNT_W-1:0] trimmed;
        logic [CNT_W-1:0] goal;
    } t_judge_req;

    typedef struct packed {
        logic             hit2;
        logic             hit1;
        logic             hit0;
        logic             is_pick;
        logic             trim;
        logic             keep;
        logic [PRI_W-1:0] pri;
    } t_judge_res;

endpackage

`default_nettype wire

// ----- hw/rtl/fpr_if.sv -----
// Channel interfaces of the focus priority request picker: request beats in, result beats out.
// Depends on fpr_pkg for field widths.
`default_nettype none

interface fpr_req_if;
    import fpr_pkg::*;
    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] req_key;
    logic [PRI_W-1:0] req_priority;

    modport source (output valid, op, req_key, req_priority, input ready);
    modport sink   (input valid, op, req_key, req_priority, output ready);
endinterface

interface fpr_rsp_if;
    import fpr_pkg::*;
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             dispatched;
    logic [KEY_W-1:0] dispatched_key;
    logic [CNT_W-1:0] pending_count;
    logic [CNT_W-1:0] trimmed_count;

    modport source (output valid, accepted, dispatched, dispatched_key, pending_count,
                    trimmed_count, input ready);
    modport sink   (input valid, accepted, dispatched, dispatched_key, pending_count,
                    trimmed_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/focus_priority_request_picker.sv -----
// Focus priority request picker: age-ordered request queue in RAM, walked one entry per cycle.
// A post makes one sweep over the queue and a tick makes two, a scan and then a sweep;
// the single RAM read port is visited once per entry per sweep.
// One item is in flight at a time; the next is taken once the result sits in the output register.
// Reset empties the queue at once (no clearing pass) and sets trim limit 32, trim slack 10.
// Depends on fpr_pkg, fpr_if, fpr_ram, fpr_cfg and fpr_judge.
`default_nettype none

module focus_priority_request_picker
    import fpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    fpr_req_if.sink                i_req,
    fpr_rsp_if.source              o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_trim_cfg  cfg;
    t_judge_req job;
    t_judge_res verdict;

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [PRI_W-1:0] r_pri, n_pri;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_pos, n_rd_pos;
    logic [CNT_W-1:0] r_wr_ptr, n_wr_ptr;
    logic             r_has2, n_has2;
    logic             r_has1, n_has1;
    logic             r_has0, n_has0;
    logic [IDX_W-1:0] r_last2, n_last2;
    logic [IDX_W-1:0] r_last1, n_last1;
    logic [IDX_W-1:0] r_last0, n_last0;
    logic [CNT_W-1:0] r_n2, n_n2;
    logic [CNT_W-1:0] r_n0, n_n0;
    logic [IDX_W-1:0] r_pick, n_pick;
    logic             r_pick_vld, n_pick_vld;
    logic             r_pick_is2, n_pick_is2;
    logic [CNT_W-1:0] r_cnt_after, n_cnt_after;
    logic [CNT_W-1:0] r_p0_after, n_p0_after;
    logic [CNT_W-1:0] r_trim_goal, n_trim_goal;
    logic [CNT_W-1:0] r_trimmed, n_trimmed;
    logic             r_acc, n_acc;
    logic [KEY_W-1:0] r_dkey, n_dkey;

    logic             r_out_vld, n_out_vld;
    logic             r_out_acc;
    logic             r_out_disp;
    logic [KEY_W-1:0] r_out_dkey;
    logic [CNT_W-1:0] r_out_cnt;
    logic [CNT_W-1:0] r_out_trim;
    logic             out_load;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic             issue;
    logic             sweep_done;
    logic [CMP_W-1:0] target;
    logic [CMP_W-1:0] excess;

    fpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fpr_judge u_judge (
        .i_job     (job),
        .o_verdict (verdict)
    );

    assign job.tick     = (r_op == OP_TICK);
    assign job.key      = r_key;
    assign job.e_key    = ram_rdata[ENTRY_W-1:PRI_W];
    assign job.e_pri    = ram_rdata[PRI_W-1:0];
    assign job.pos      = r_rd_pos;
    assign job.pick_vld = r_pick_vld;
    assign job.pick_is2 = r_pick_is2;
    assign job.pick     = r_pick;
    assign job.trimmed  = r_trimmed;
    assign job.goal     = r_trim_goal;

    assign i_req.ready = (r_state == ST_IDLE);
    assign issue       = (r_rd_ptr < r_count);
    assign sweep_done  = (r_rd_ptr == r_count) && !r_rd_vld;
    assign ram_raddr   = r_rd_ptr[IDX_W-1:0];
    assign ram_waddr   = r_wr_ptr[IDX_W-1:0];

    assign target = (CMP_W'(cfg.slack) >= CMP_W'(cfg.limit))
                    ? '0 : CMP_W'(cfg.limit) - CMP_W'(cfg.slack);
    assign excess = CMP_W'(r_cnt_after) - target;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_pri       = r_pri;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_rd_vld    = 1'b0;
        n_rd_pos    = r_rd_pos;
        n_wr_ptr    = r_wr_ptr;
        n_has2      = r_has2;
        n_has1      = r_has1;
        n_has0      = r_has0;
        n_last2     = r_last2;
        n_last1     = r_last1;
        n_last0     = r_last0;
        n_n2        = r_n2;
        n_n0        = r_n0;
        n_pick      = r_pick;
        n_pick_vld  = r_pick_vld;
        n_pick_is2  = r_pick_is2;
        n_cnt_after = r_cnt_after;
        n_p0_after  = r_p0_after;
        n_trim_goal = r_trim_goal;
        n_trimmed   = r_trimmed;
        n_acc       = r_acc;
        n_dkey      = r_dkey;
        ram_we      = 1'b0;
        ram_wdata   = ram_rdata;
        out_load    = 1'b0;
        n_out_vld   = r_out_vld && !o_rsp.ready;

        if ((r_state == ST_POST_SWEEP) || (r_state == ST_TICK_SCAN)
            || (r_state == ST_TICK_SWEEP)) begin
            n_rd_vld = issue;
            n_rd_pos = r_rd_ptr[IDX_W-1:0];
            if (issue) begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op        = i_req.op;
                    n_key       = i_req.req_key;
                    n_pri       = (i_req.req_priority > PRI_FOCUS) ? PRI_FOCUS
                                                                   : i_req.req_priority;
                    n_rd_ptr    = '0;
                    n_wr_ptr    = '0;
                    n_has2      = 1'b0;
                    n_has1      = 1'b0;
                    n_has0      = 1'b0;
                    n_n2        = '0;
                    n_n0        = '0;
                    n_pick_vld  = 1'b0;
                    n_pick_is2  = 1'b0;
                    n_trim_goal = '0;
                    n_trimmed   = '0;
                    n_acc       = 1'b0;
                    n_dkey      = '0;
                    n_state     = (i_req.op == OP_TICK) ? ST_TICK_SCAN : ST_POST_SWEEP;
                end
            end
            ST_POST_SWEEP: begin
                if (r_rd_vld && verdict.keep) begin
                    ram_we   = 1'b1;
                    n_wr_ptr = r_wr_ptr + 1'b1;
                end
                if (sweep_done) begin
                    if (r_wr_ptr < CNT_W'(QUEUE_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_key, r_pri};
                        n_count   = r_wr_ptr + 1'b1;
                        n_acc     = 1'b1;
                    end else begin
                        n_count = r_wr_ptr;
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_TICK_SCAN: begin
                if (r_rd_vld) begin
                    if (verdict.hit2) begin
                        n_has2  = 1'b1;
                        n_last2 = r_rd_pos;
                        n_n2    = r_n2 + 1'b1;
                    end
                    if (verdict.hit1) begin
                        n_has1  = 1'b1;
                        n_last1 = r_rd_pos;
                    end
                    if (verdict.hit0) begin
                        n_has0  = 1'b1;
                        n_last0 = r_rd_pos;
                        n_n0    = r_n0 + 1'b1;
                    end
                end
                if (sweep_done) begin
                    n_pick_vld = r_has2 || r_has1 || r_has0;
                    n_pick_is2 = r_has2;
                    if (r_has2) begin
                        n_pick     = r_last2;
                        n_p0_after = r_n0 + r_n2 - 1'b1;
                    end else if (r_has1) begin
                        n_pick     = r_last1;
                        n_p0_after = r_n0;
                    end else begin
                        n_pick     = r_last0;
                        n_p0_after = r_has0 ? r_n0 - 1'b1 : r_n0;
                    end
                    n_cnt_after = (r_has2 || r_has1 || r_has0) ? r_count - 1'b1 : r_count;
                    n_rd_ptr    = '0;
                    n_wr_ptr    = '0;
                    n_state     = ST_TICK_PLAN;
                end
            end
            ST_TICK_PLAN: begin
                if (CMP_W'(r_cnt_after) > CMP_W'(cfg.limit)) begin
                    n_trim_goal = (excess < CMP_W'(r_p0_after)) ? CNT_W'(excess) : r_p0_after;
                end else begin
                    n_trim_goal = '0;
                end
                n_state = ST_TICK_SWEEP;
            end
            ST_TICK_SWEEP: begin
                if (r_rd_vld) begin
                    if (verdict.is_pick) begin
                        n_dkey = ram_rdata[ENTRY_W-1:PRI_W];
                    end
                    if (verdict.trim) begin
                        n_trimmed = r_trimmed + 1'b1;
                    end
                    if (verdict.keep) begin
                        ram_we    = 1'b1;
                        ram_wdata = {ram_rdata[ENTRY_W-1:PRI_W], verdict.pri};
                        n_wr_ptr  = r_wr_ptr + 1'b1;
                    end
                end
                if (sweep_done) begin
                    n_count = r_wr_ptr;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_vld || o_rsp.ready) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_trim_goal <= '0;
            r_trimmed   <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_vld   <= n_out_vld;
            r_trim_goal <= n_trim_goal;
            r_trimmed   <= n_trimmed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_pri       <= n_pri;
        r_rd_ptr    <= n_rd_ptr;
        r_rd_pos    <= n_rd_pos;
        r_wr_ptr    <= n_wr_ptr;
        r_has2      <= n_has2;
        r_has1      <= n_has1;
        r_has0      <= n_has0;
        r_last2     <= n_last2;
        r_last1     <= n_last1;
        r_last0     <= n_last0;
        r_n2        <= n_n2;
        r_n0        <= n_n0;
        r_pick      <= n_pick;
        r_pick_vld  <= n_pick_vld;
        r_pick_is2  <= n_pick_is2;
        r_cnt_after <= n_cnt_after;
        r_p0_after  <= n_p0_after;
        r_acc       <= n_acc;
        r_dkey      <= n_dkey;
        if (out_load) begin
            r_out_acc  <= r_acc;
            r_out_disp <= r_pick_vld;
            r_out_dkey <= r_dkey;
            r_out_cnt  <= r_count;
            r_out_trim <= r_trimmed;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.accepted       = r_out_acc;
    assign o_rsp.dispatched     = r_out_disp;
    assign o_rsp.dispatched_key = r_out_dkey;
    assign o_rsp.pending_count  = r_out_cnt;
    assign o_rsp.trimmed_count  = r_out_trim;

    // The queue never holds more entries than the RAM has rows.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // Compaction writes must never overtake the entry being read.
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_wr_ptr <= CNT_W'(r_rd_pos)))
        else $error("compaction write pointer passed read position");

    // Trimming stops once the planned number of entries is gone.
    a_trim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_SWEEP) |-> (r_trimmed <= r_trim_goal))
        else $error("trimmed more entries than planned");

    // An accepted request beat makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request channel ready right after accepting a beat");

endmodule

`default_nettype wire

// ----- hw/rtl/fpr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fpr_cfg.sv -----
// APB register file of the focus priority request picker: trim limit and trim slack.
// Depends on fpr_pkg.
`default_nettype none

module fpr_cfg
    import fpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_trim_cfg              o_cfg
);

    logic [LIMIT_W-1:0] r_limit;
    logic [SLACK_W-1:0] r_slack;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_slack <= SLACK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                CFG_TRIM_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                CFG_TRIM_SLACK: r_slack <= pwdata[SLACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            CFG_TRIM_LIMIT: prdata = APB_DW'(r_limit);
            CFG_TRIM_SLACK: prdata = APB_DW'(r_slack);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.limit = r_limit;
    assign o_cfg.slack = r_slack;

endmodule

`default_nettype wire

// ----- hw/rtl/fpr_judge.sv -----
// Shared per-entry decision unit: key match, priority classes, pick, demotion and trim.
// Depends on fpr_pkg for the request and verdict structs.
`default_nettype none

module fpr_judge
    import fpr_pkg::*;
(
    input  t_judge_req i_job,
    output t_judge_res o_verdict
);

    logic             match;
    logic             demote;
    logic [PRI_W-1:0] pri_out;

    always_comb begin
        o_verdict.hit2    = (i_job.e_pri == PRI_FOCUS);
        o_verdict.hit1    = (i_job.e_pri == PRI_NEAR);
        o_verdict.hit0    = (i_job.e_pri == PRI_VIEW);
        o_verdict.is_pick = i_job.tick && i_job.pick_vld && (i_job.pos == i_job.pick);

        // Older focused entries lose their focus when the newest one goes out.
        demote  = i_job.tick && i_job.pick_is2 && o_verdict.hit2 && (i_job.pos < i_job.pick);
        pri_out = demote ? PRI_VIEW : i_job.e_pri;

        o_verdict.trim = i_job.tick && !o_verdict.is_pick && (pri_out == PRI_VIEW)
                         && (i_job.trimmed < i_job.goal);
        match          = !i_job.tick && (i_job.e_key == i_job.key);

        o_verdict.keep = !(match || o_verdict.is_pick || o_verdict.trim);
        o_verdict.pri  = pri_out;
    end

endmodule

`default_nettype wire
